@@ design/nlsl_pkg.sv @@
// Shared types and constants for the nearest lower symbol lookup block.
package nlsl_pkg;

  // Fixed field widths
  localparam int WORD_W        = 32;
  localparam int ENTRY_INDEX_W = 10;
  localparam int SYM_COUNT_W   = 11;
  // Wide enough for a saturated scan length at the largest table size
  localparam int SCAN_CNT_W    = 17;

  // Defaults for the top level parameters
  localparam int DEF_MAX_SYMBOLS = 1024;
  localparam int DEF_QUEUE_DEPTH = 2;

  // Configuration port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  typedef enum logic [0:0] {
    REG_SYMBOL_COUNT  = 1'b0,
    REG_NAMES_PRESENT = 1'b1
  } reg_idx_t;

  // Input command codes
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Operation classes handed from front end to back end
  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_SCAN = 2'd1,
    OP_MISS = 2'd2
  } op_kind_t;

  typedef struct packed {
    op_kind_t                 kind;
    logic [ENTRY_INDEX_W-1:0] index;
    logic [WORD_W-1:0]        value;
    logic [WORD_W-1:0]        name;
    logic [WORD_W-1:0]        addr;
    logic [SCAN_CNT_W-1:0]    count;
  } op_t;

  // Configuration seen by the front end
  typedef struct packed {
    logic [SYM_COUNT_W-1:0] symbol_count;
    logic                   names_present;
  } cfg_t;

  // Handshake between queue and back end
  typedef struct packed {
    logic valid;
    op_t  op;
  } queue_head_t;

  typedef enum logic [1:0] {
    B_IDLE  = 2'd0,
    B_SCAN  = 2'd1,
    B_DRAIN = 2'd2,
    B_DONE  = 2'd3
  } back_state_t;

endpackage

@@ design/nlsl_if.sv @@
// Request and response channel interfaces for the symbol lookup block.
interface nlsl_req_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [9:0]  entry_index;
  logic [31:0] entry_value;
  logic [31:0] entry_name_offset;
  logic [31:0] query_address;

  modport source (output valid, cmd, entry_index, entry_value, entry_name_offset,
                  query_address, input ready);
  modport sink (input valid, cmd, entry_index, entry_value, entry_name_offset,
                query_address, output ready);
endinterface

interface nlsl_rsp_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [31:0] name_offset;
  logic [31:0] distance;

  modport source (output valid, found, name_offset, distance, input ready);
  modport sink (input valid, found, name_offset, distance, output ready);
endinterface

@@ design/nearest_lower_symbol_lookup.sv @@
// Top level of the nearest lower symbol lookup block.
//
// Requests arrive on req: cmd selects a load (writes entry_index with
// entry_value and entry_name_offset, no response) or a query (searches the
// first symbol_count entries for the largest value below query_address and
// above zero; the lowest index wins a tie). Each query gives one transfer on
// rsp: found, name_offset and distance; a miss returns all zeros.
// Registers on the APB port: symbol_count at 0x0, names_present at 0x4.
// Write them only while no request is in flight.
// A front stage and a short queue take requests while the back end works.
// The back end writes a load to the table from its idle state, sends a query
// that misses outright straight to the response state, and for a scanning
// query reads N = min(symbol_count, MAX_SYMBOLS) entries, then drains; the single
// table read port reads one entry per cycle.
// A stalled response holds in the output register; the back end then waits,
// the queue fills and req.ready drops.
// Reset clears the registers and all control state; table contents are
// undefined until loaded.
module nearest_lower_symbol_lookup
  import nlsl_pkg::*;
#(
  parameter int MAX_SYMBOLS = DEF_MAX_SYMBOLS,
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  nlsl_req_if.sink              req,
  nlsl_rsp_if.source            rsp,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t        cfg;
  reg_idx_t    reg_idx;
  logic        cfg_write;
  logic        push;
  op_t         push_op;
  logic        queue_full;
  logic        pop;
  queue_head_t head;

  // Register decode
  assign pready    = 1'b1;
  assign reg_idx   = reg_idx_t'(paddr[2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_SYMBOL_COUNT:  cfg.symbol_count  <= pwdata[SYM_COUNT_W-1:0];
        REG_NAMES_PRESENT: cfg.names_present <= pwdata[0];
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_idx)
      REG_SYMBOL_COUNT:  prdata = APB_DATA_W'(cfg.symbol_count);
      REG_NAMES_PRESENT: prdata = APB_DATA_W'(cfg.names_present);
    endcase
  end

  nlsl_front #(
    .MAX_SYMBOLS(MAX_SYMBOLS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg       (cfg),
    .push      (push),
    .push_op   (push_op),
    .queue_full(queue_full)
  );

  nlsl_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .push_op(push_op),
    .full   (queue_full),
    .pop    (pop),
    .head   (head)
  );

  nlsl_back #(
    .MAX_SYMBOLS(MAX_SYMBOLS)
  ) u_back (
    .clk (clk),
    .rst (rst),
    .head(head),
    .pop (pop),
    .rsp (rsp)
  );

endmodule

@@ design/nlsl_front.sv @@
// Front end: accepts request transfers, classifies them and stages them for the queue.
module nlsl_front
  import nlsl_pkg::*;
#(
  parameter int MAX_SYMBOLS = DEF_MAX_SYMBOLS
) (
  input  logic        clk,
  input  logic        rst,
  nlsl_req_if.sink    req,
  input  cfg_t        cfg,
  output logic        push,
  output op_t         push_op,
  input  logic        queue_full
);

  logic stg_valid;
  logic stg_valid_next;
  op_t  stg_op;
  op_t  op_class;
  logic accept;
  logic keep;

  // Drain the stage whenever the queue has room
  assign push      = stg_valid && !queue_full;
  assign push_op   = stg_op;
  assign req.ready = !stg_valid || !queue_full;
  assign accept    = req.valid && req.ready;

  // Classify the incoming item
  always_comb begin
    op_class       = '0;
    op_class.index = req.entry_index;
    op_class.value = req.entry_value;
    op_class.name  = req.entry_name_offset;
    op_class.addr  = req.query_address;
    if (32'(cfg.symbol_count) > 32'(MAX_SYMBOLS)) begin
      op_class.count = SCAN_CNT_W'(MAX_SYMBOLS);
    end else begin
      op_class.count = SCAN_CNT_W'(cfg.symbol_count);
    end
    keep = 1'b1;
    if (req.cmd == CMD_LOAD) begin
      op_class.kind = OP_LOAD;
      // drop loads beyond the table
      keep = 32'(req.entry_index) < 32'(MAX_SYMBOLS);
    end else if (!cfg.names_present || cfg.symbol_count == '0) begin
      op_class.kind = OP_MISS;
    end else begin
      op_class.kind = OP_SCAN;
    end
  end

  always_comb begin
    stg_valid_next = stg_valid;
    if (push) begin
      stg_valid_next = 1'b0;
    end
    if (accept) begin
      stg_valid_next = keep;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else begin
      stg_valid <= stg_valid_next;
    end
  end

  // Hold the staged operation until it moves on
  always_ff @(posedge clk) begin
    if (accept) begin
      stg_op <= op_class;
    end
  end

endmodule

@@ design/nlsl_queue.sv @@
// Short operation queue between the front end and the back end.
module nlsl_queue
  import nlsl_pkg::*;
#(
  parameter int DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  op_t         push_op,
  output logic        full,
  input  logic        pop,
  output queue_head_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  op_t              slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full       = fill == CNT_W'(DEPTH);
  assign head.valid = fill != '0;
  assign head.op    = slots[rd_ptr];

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + CNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

endmodule

@@ design/nlsl_back.sv @@
// Back end: symbol table memory, scan sequencer and response register.
module nlsl_back
  import nlsl_pkg::*;
#(
  parameter int MAX_SYMBOLS = DEF_MAX_SYMBOLS
) (
  input  logic        clk,
  input  logic        rst,
  input  queue_head_t head,
  output logic        pop,
  nlsl_rsp_if.source  rsp
);

  localparam int IDX_W = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
  localparam int CNT_W = $clog2(MAX_SYMBOLS + 1);

  back_state_t       state;
  back_state_t       state_next;

  logic [2*WORD_W-1:0] mem [MAX_SYMBOLS];
  logic [2*WORD_W-1:0] rd_data;
  logic                mem_we;
  logic [IDX_W-1:0]    wr_addr;
  logic [IDX_W-1:0]    rd_addr;

  logic [CNT_W-1:0]  rd_cnt;
  logic [CNT_W-1:0]  scan_n;
  logic [WORD_W-1:0] scan_addr;
  logic [WORD_W-1:0] best_val;
  logic [WORD_W-1:0] best_name;
  logic              best_hit;
  logic              rd_vld;
  logic              issue;
  logic              last_issue;
  logic              out_load;
  logic              better;
  logic [WORD_W-1:0] rd_val;
  logic [WORD_W-1:0] rd_name;

  logic              out_valid;
  logic              out_found;
  logic [WORD_W-1:0] out_name;
  logic [WORD_W-1:0] out_dist;

  assign wr_addr = IDX_W'(head.op.index);
  assign rd_addr = rd_cnt[IDX_W-1:0];
  assign rd_val  = rd_data[2*WORD_W-1:WORD_W];
  assign rd_name = rd_data[WORD_W-1:0];
  assign better  = (rd_val < scan_addr) && (rd_val > best_val);

  // Control outputs of the sequencer
  always_comb begin
    pop        = (state == B_IDLE) && head.valid;
    mem_we     = pop && (head.op.kind == OP_LOAD);
    issue      = state == B_SCAN;
    last_issue = issue && ((rd_cnt + CNT_W'(1)) == scan_n);
    out_load   = (state == B_DONE) && (!out_valid || rsp.ready);
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (head.valid) begin
          unique case (head.op.kind)
            OP_SCAN: state_next = B_SCAN;
            OP_MISS: state_next = B_DONE;
            default: state_next = B_IDLE;
          endcase
        end
      end
      B_SCAN: begin
        if (last_issue) begin
          state_next = B_DRAIN;
        end
      end
      B_DRAIN: state_next = B_DONE;
      B_DONE: begin
        if (out_load) begin
          state_next = B_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= B_IDLE;
      rd_vld <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= issue;
    end
  end

  // Symbol table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= {head.op.value, head.op.name};
    end
    rd_data <= mem[rd_addr];
  end

  // Scan datapath: start, advance and keep the best candidate
  always_ff @(posedge clk) begin
    if (pop && head.op.kind == OP_SCAN) begin
      scan_addr <= head.op.addr;
      scan_n    <= CNT_W'(head.op.count);
      rd_cnt    <= '0;
      best_val  <= '0;
      best_name <= '0;
      best_hit  <= 1'b0;
    end else if (pop && head.op.kind == OP_MISS) begin
      best_val  <= '0;
      best_name <= '0;
      best_hit  <= 1'b0;
    end else begin
      if (issue) begin
        rd_cnt <= rd_cnt + CNT_W'(1);
      end
      if (rd_vld && better) begin
        best_val  <= rd_val;
        best_name <= rd_name;
        best_hit  <= 1'b1;
      end
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_found <= best_hit;
      out_name  <= best_hit ? best_name : '0;
      out_dist  <= best_hit ? (scan_addr - best_val) : '0;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.found       = out_found;
  assign rsp.name_offset = out_name;
  assign rsp.distance    = out_dist;

endmodule

@@ design/nlsl_checker.sv @@
// Port-level checks for the symbol lookup block, bound to its top level.
module nlsl_checker (
  input logic        clk,
  input logic        rst,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic        rsp_found,
  input logic [31:0] rsp_name_offset,
  input logic [31:0] rsp_distance
);

  // Hold a stalled response
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found)
      && $stable(rsp_name_offset) && $stable(rsp_distance))
    else $error("stalled response changed");

  // A miss carries no name and no distance
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_found |-> rsp_name_offset == '0 && rsp_distance == '0)
    else $error("miss with nonzero payload");

  // A hit symbol lies strictly below the query address
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_found |-> rsp_distance != '0)
    else $error("hit with zero distance");

  // No response right after reset
  assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("response valid after reset");

endmodule

bind nearest_lower_symbol_lookup nlsl_checker u_nlsl_checker (
  .clk            (clk),
  .rst            (rst),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_found      (rsp.found),
  .rsp_name_offset(rsp.name_offset),
  .rsp_distance   (rsp.distance)
);

@@ verif/nlsl_tb_pkg.sv @@
`timescale 1ns / 1ps
// Result predictor and scoreboard for the symbol lookup testbench.
package nlsl_tb_pkg;
  import nlsl_pkg::*;

  localparam int TABLE_DEPTH = DEF_MAX_SYMBOLS;

  typedef struct packed {
    logic              found;
    logic [WORD_W-1:0] name_offset;
    logic [WORD_W-1:0] distance;
  } lookup_result_t;

  class symbol_lookup_checker;
    logic [WORD_W-1:0]      sym_value [TABLE_DEPTH];
    logic [WORD_W-1:0]      sym_name [TABLE_DEPTH];
    logic [SYM_COUNT_W-1:0] scan_limit;
    logic                   names_on;
    lookup_result_t         pending_lookups [$];
    int                     mismatch_count;

    function new();
      foreach (sym_value[i]) begin
        sym_value[i] = '0;
        sym_name[i]  = '0;
      end
      scan_limit     = '0;
      names_on       = 1'b0;
      mismatch_count = 0;
    endfunction

    // Mirror a register write; upper data bits are dropped
    function void set_register(reg_idx_t idx, logic [APB_DATA_W-1:0] data);
      case (idx)
        REG_SYMBOL_COUNT:  scan_limit = data[SYM_COUNT_W-1:0];
        REG_NAMES_PRESENT: names_on = data[0];
        default: ;
      endcase
    endfunction

    // Largest nonzero value strictly below the address; first index wins a tie
    function lookup_result_t predict_lookup(logic [WORD_W-1:0] addr);
      lookup_result_t    res;
      logic [WORD_W-1:0] best;
      int                n;
      res  = '0;
      best = '0;
      if (!names_on) return res;
      n = (scan_limit > TABLE_DEPTH) ? TABLE_DEPTH : int'(scan_limit);
      for (int i = 0; i < n; i++) begin
        if (sym_value[i] < addr && sym_value[i] > best) begin
          best            = sym_value[i];
          res.found       = 1'b1;
          res.name_offset = sym_name[i];
        end
      end
      if (res.found) res.distance = addr - best;
      return res;
    endfunction

    // Apply a load to the table copy, or queue the answer to a query
    function void note_request(logic cmd, logic [ENTRY_INDEX_W-1:0] idx,
                               logic [WORD_W-1:0] value, logic [WORD_W-1:0] name,
                               logic [WORD_W-1:0] addr);
      if (cmd == CMD_LOAD) begin
        sym_value[idx] = value;
        sym_name[idx]  = name;
      end else begin
        pending_lookups.push_back(predict_lookup(addr));
      end
    endfunction

    // Compare one response transfer with the oldest queued answer
    function void check_response(lookup_result_t got);
      lookup_result_t want;
      if (pending_lookups.size() == 0) begin
        $error("unexpected response: found %0b name_offset 0x%08h distance 0x%08h",
               got.found, got.name_offset, got.distance);
        mismatch_count++;
        return;
      end
      want = pending_lookups.pop_front();
      if (got.found !== want.found) begin
        $error("found: expected %0b, actual %0b", want.found, got.found);
        mismatch_count++;
      end
      if (got.name_offset !== want.name_offset) begin
        $error("name_offset: expected 0x%08h, actual 0x%08h",
               want.name_offset, got.name_offset);
        mismatch_count++;
      end
      if (got.distance !== want.distance) begin
        $error("distance: expected 0x%08h, actual 0x%08h", want.distance, got.distance);
        mismatch_count++;
      end
    endfunction

    function bit all_returned();
      return pending_lookups.size() == 0;
    endfunction
  endclass

endpackage

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// Top testbench: drives loads, queries and register writes, checks every lookup.
module tb;
  import nlsl_pkg::*;
  import nlsl_tb_pkg::*;

  localparam int QUIET_LIMIT   = 10000;
  localparam int DRAIN_CYCLES  = 16;
  localparam int HOLD_CYCLES   = 400;
  localparam int SEGMENTS      = 12;
  localparam int SEGMENT_ITEMS = 48;
  localparam int HOLD_SEGMENT  = 8;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  nlsl_req_if req_ch ();
  nlsl_rsp_if rsp_ch ();

  nearest_lower_symbol_lookup i_dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  symbol_lookup_checker lookups;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_rsp      = 1'b0;
  int quiet_cycles  = 0;
  bit loaded [TABLE_DEPTH];
  // Number of slots written contiguously from slot 0; scans never go past it
  int prefix        = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort when no transfer of any kind happens for too long
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Response side: check each transfer, then pick ready for the next cycle
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_ch.valid && rsp_ch.ready) begin
        lookups.check_response({rsp_ch.found, rsp_ch.name_offset, rsp_ch.distance});
      end
      if (hold_rsp) begin
        hold_rsp = 1'b0;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Offer one request after random idle cycles and hold it until taken
  task automatic send_request(logic cmd, logic [ENTRY_INDEX_W-1:0] idx,
                              logic [WORD_W-1:0] value, logic [WORD_W-1:0] name,
                              logic [WORD_W-1:0] addr);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid             <= 1'b1;
    req_ch.cmd               <= cmd;
    req_ch.entry_index       <= idx;
    req_ch.entry_value       <= value;
    req_ch.entry_name_offset <= name;
    req_ch.query_address     <= addr;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    lookups.note_request(cmd, idx, value, name, addr);
    if (cmd == CMD_LOAD) begin
      loaded[idx] = 1'b1;
      while (prefix < TABLE_DEPTH && loaded[prefix]) prefix++;
    end
  endtask

  // Unused fields carry random bits
  task automatic load_entry(logic [ENTRY_INDEX_W-1:0] idx, logic [WORD_W-1:0] value,
                            logic [WORD_W-1:0] name);
    send_request(CMD_LOAD, idx, value, name, $urandom());
  endtask

  task automatic query(logic [WORD_W-1:0] addr);
    send_request(CMD_QUERY, ENTRY_INDEX_W'($urandom_range(0, TABLE_DEPTH - 1)),
                 $urandom(), $urandom(), addr);
  endtask

  // Setup and access phase of one write; psel is left high
  task automatic apb_write(reg_idx_t idx, logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    lookups.set_register(idx, data);
  endtask

  // Write both registers back to back; junk in the upper bits must be dropped
  task automatic apply_config(int count, bit names);
    apb_write(REG_SYMBOL_COUNT, ($urandom() & ~32'h7FF) | APB_DATA_W'(count));
    apb_write(REG_NAMES_PRESENT, ($urandom() & ~32'h1) | APB_DATA_W'(names));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Drop valid, wait for every answer, then let trailing loads retire
  task automatic settle();
    req_ch.valid <= 1'b0;
    while (!lookups.all_returned()) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Symbol values biased toward boundaries and repeats of stored values
  function automatic logic [WORD_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return $urandom_range(1, 16);
      3:       return lookups.sym_value[$urandom_range(0, prefix - 1)];
      default: return $urandom();
    endcase
  endfunction

  // Addresses near stored values hit the strict comparison edges
  function automatic logic [WORD_W-1:0] pick_address();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return $urandom_range(0, 18);
      3, 4:    return lookups.sym_value[$urandom_range(0, prefix - 1)] + $urandom_range(0, 2);
      default: return $urandom();
    endcase
  endfunction

  // Mix of queries and loads: grow the scanned prefix, rewrite it, or write anywhere
  task automatic run_segment(int items);
    logic [ENTRY_INDEX_W-1:0] idx;
    for (int k = 0; k < items; k++) begin
      if ($urandom_range(0, 99) < 55) begin
        query(pick_address());
      end else begin
        case ($urandom_range(0, 2))
          0:       idx = (prefix < TABLE_DEPTH) ? ENTRY_INDEX_W'(prefix)
                                                : ENTRY_INDEX_W'($urandom_range(0, TABLE_DEPTH - 1));
          1:       idx = ENTRY_INDEX_W'($urandom_range(0, prefix - 1));
          default: idx = ENTRY_INDEX_W'($urandom_range(0, TABLE_DEPTH - 1));
        endcase
        load_entry(idx, pick_value(), $urandom());
      end
    end
  endtask

  initial begin
    int mode;
    int count_cfg;
    lookups = new();
    rst                      <= 1'b1;
    psel                     <= 1'b0;
    penable                  <= 1'b0;
    pwrite                   <= 1'b0;
    paddr                    <= '0;
    pwdata                   <= '0;
    req_ch.valid             <= 1'b0;
    req_ch.cmd               <= CMD_LOAD;
    req_ch.entry_index       <= '0;
    req_ch.entry_value       <= '0;
    req_ch.entry_name_offset <= '0;
    req_ch.query_address     <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    apply_config(0, 1'b0);

    // Directed table: zero value, tie, all-ones value, value one, top slot
    load_entry(0, 32'h0000_0000, 32'hA5A5_0000);
    load_entry(1, 32'h0000_1000, 32'h0000_0011);
    load_entry(2, 32'h0000_1000, 32'h0000_0022);
    load_entry(3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    load_entry(4, 32'h0000_0001, 32'h0000_0000);
    load_entry(5, 32'h8000_0000, 32'h5A5A_5A5A);
    load_entry(TABLE_DEPTH - 1, 32'h0000_0FFF, 32'h0000_03FF);
    // Empty scan misses
    query(32'h0000_2000);
    settle();
    // No name table: miss whatever the table holds
    apply_config(6, 1'b0);
    query(32'hFFFF_FFFF);
    settle();
    apply_config(6, 1'b1);
    query(32'h0000_0000);
    query(32'h0000_0001);
    query(32'h0000_0002);
    query(32'h0000_1000);
    query(32'h0000_1001);
    query(32'h8000_0001);
    query(32'hFFFF_FFFF);
    settle();
    // Only the zero-valued slot is scanned
    apply_config(1, 1'b1);
    query(32'hFFFF_FFFF);

    // Random segments: sender mostly busy, then receiver, then neither idles
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      settle();
      mode          = seg / (SEGMENTS / 3);
      send_idle_pct = (mode == 0) ? 29 : (mode == 1) ? 87 : 0;
      recv_idle_pct = (mode == 0) ? 87 : (mode == 1) ? 29 : 0;
      case ($urandom_range(0, 3))
        0:       count_cfg = 0;
        1:       count_cfg = prefix;
        default: count_cfg = $urandom_range(1, prefix);
      endcase
      apply_config(count_cfg, $urandom_range(0, 4) != 0);
      if (seg == HOLD_SEGMENT) hold_rsp = 1'b1;
      run_segment(SEGMENT_ITEMS);
    end

    // Scan the whole loaded prefix, then again with no name table
    settle();
    apply_config(prefix, 1'b1);
    repeat (4) query(pick_address());
    query(32'hFFFF_FFFF);
    settle();
    apply_config(prefix, 1'b0);
    query(pick_address());
    settle();

    if (lookups.mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
